// ----- rtl/core/thc_pkg.sv -----
// Package for the thermostat heater and fan controller.
// Holds widths, reset values, band offsets, output codes and the status struct.
// It depends on nothing; every module of the block imports it.
package thc_pkg;

    localparam int SAMPLES_PER_AVERAGE_DEF = 10;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 16;
    localparam int CNT_W     = 4;
    localparam int TEMP_W    = 12;
    localparam int LIMIT_W   = 8;
    localparam int GAIN_W    = 8;
    localparam int CODE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // Signed width for band compares: setpoint plus or minus 64 never wraps.
    localparam int CMP_W = TEMP_W + 2;

    localparam logic [TEMP_W-1:0]  TARGET_RST = 12'd400;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 8'd24;
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 8'd178;

    localparam logic signed [CMP_W-1:0] HYST_BAND  = 14'sd32;
    localparam logic signed [CMP_W-1:0] WIDE_BAND  = 14'sd64;
    localparam logic signed [CMP_W-1:0] REARM_BAND = 14'sd24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

    localparam logic [CODE_W-1:0] HEAT_FULL = 4'd0;
    localparam logic [CODE_W-1:0] HEAT_HIGH = 4'd2;
    localparam logic [CODE_W-1:0] HEAT_LOW  = 4'd5;
    localparam logic [CODE_W-1:0] HEAT_OFF  = 4'd11;

    localparam logic [CODE_W-1:0] FAN_FULL = 4'd0;
    localparam logic [CODE_W-1:0] FAN_HIGH = 4'd3;
    localparam logic [CODE_W-1:0] FAN_LOW  = 4'd6;
    localparam logic [CODE_W-1:0] FAN_OFF  = 4'd11;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              held;
        logic              heater_on;
        logic [CODE_W-1:0] heater_code;
        logic [CODE_W-1:0] fan_code;
    } t_status;

endpackage

// ----- rtl/core/thc_ctrl.sv -----
// Spike filter, band coders and heater hysteresis latch.
// Its state registers are the result payload. Depends on thc_pkg.
module thc_ctrl import thc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [TEMP_W-1:0]  i_reading,
    input  logic [TEMP_W-1:0]  i_target,
    input  logic [LIMIT_W-1:0] i_spike_limit,
    output t_status            o_status
);

    logic [TEMP_W-1:0] r_cur, n_cur;
    logic [TEMP_W-1:0] r_last, n_last;
    logic              r_hold, n_hold;
    logic              r_latch, n_latch;
    logic              r_rearm, n_rearm;
    logic [CODE_W-1:0] r_heat, n_heat;
    logic [CODE_W-1:0] r_fan, n_fan;

    logic [TEMP_W-1:0]       diff;
    logic                    spike;
    logic signed [CMP_W-1:0] t_s, tg_s;

    always_comb begin
        diff  = (i_reading > r_last) ? i_reading - r_last : r_last - i_reading;
        spike = !r_hold && (diff > {{(TEMP_W-LIMIT_W){1'b0}}, i_spike_limit});

        n_hold = spike;
        n_cur  = spike ? r_last : i_reading;
        n_last = spike ? r_last : i_reading;

        t_s  = $signed({2'b00, n_cur});
        tg_s = $signed({2'b00, i_target});

        n_heat = r_heat;
        if (t_s > tg_s - HYST_BAND && t_s < tg_s + HYST_BAND) begin
            if (r_latch) begin
                n_heat = HEAT_LOW;
            end
        end else if (t_s > tg_s - WIDE_BAND && t_s < tg_s - HYST_BAND) begin
            n_heat = HEAT_HIGH;
        end else if (t_s < tg_s - WIDE_BAND) begin
            n_heat = HEAT_FULL;
        end else begin
            n_heat = HEAT_OFF;
        end

        n_fan   = r_fan;
        n_rearm = r_rearm;
        if (t_s > tg_s && t_s < tg_s + HYST_BAND) begin
            if (!r_latch && r_rearm) begin
                n_fan   = FAN_LOW;
                n_rearm = 1'b0;
            end
        end else if (t_s > tg_s + HYST_BAND && t_s < tg_s + WIDE_BAND) begin
            n_fan = FAN_HIGH;
        end else if (t_s >= tg_s + WIDE_BAND) begin
            n_fan = FAN_FULL;
        end else begin
            n_fan = FAN_OFF;
        end
        if (t_s < tg_s - REARM_BAND) begin
            n_rearm = 1'b1;
        end

        // The latch flips only once the reading leaves the hysteresis band.
        n_latch = r_latch;
        if (!r_latch && t_s < tg_s - HYST_BAND) begin
            n_latch = 1'b1;
        end else if (r_latch && t_s > tg_s + HYST_BAND) begin
            n_latch = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_last  <= '0;
            r_hold  <= 1'b0;
            r_latch <= 1'b0;
            r_rearm <= 1'b1;
            r_heat  <= '0;
            r_fan   <= '0;
        end else if (i_step) begin
            r_cur   <= n_cur;
            r_last  <= n_last;
            r_hold  <= n_hold;
            r_latch <= n_latch;
            r_rearm <= n_rearm;
            r_heat  <= n_heat;
            r_fan   <= n_fan;
        end
    end

    assign o_status.temp        = r_cur;
    assign o_status.held        = r_hold;
    assign o_status.heater_on   = r_latch;
    assign o_status.heater_code = r_heat;
    assign o_status.fan_code    = r_fan;

endmodule

// ----- rtl/core/thermostat_heater_fan_controller.sv -----
// Top level of the thermostat heater and fan controller.
// Holds the window accumulator, the scaling pipeline and the config registers;
// depends on thc_pkg and thc_ctrl.
//
//   channel   direction  handshake              payload
//   sample    in         i_valid / o_ready      i_sample
//   result    out        o_valid / i_ready      o_updated, o_temperature, o_reading_held,
//                                               o_heater_on, o_heater_compare, o_fan_compare
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One sample beat is accepted every cycle while the result side is not stalled; its result beat
// follows the divide stage, the gain multiply stage and the control update.
// The pipeline moves as one: it advances whenever the result register is empty or
// its beat is being taken, so a stalled result holds the whole pipe and o_ready.
// Reset is synchronous and active low and gives the listed register defaults.
// Configuration beats are always taken; index three is ignored.
module thermostat_heater_fan_controller import thc_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_updated,
    output logic [TEMP_W-1:0]    o_temperature,
    output logic                 o_reading_held,
    output logic                 o_heater_on,
    output logic [CODE_W-1:0]    o_heater_compare,
    output logic [CODE_W-1:0]    o_fan_compare,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Division of the window sum by the window length is a multiply by a
    // rounded-up reciprocal; with this shift it is exact for every 16-bit sum.
    localparam int SHIFT  = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SHIFT + SUM_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
    localparam logic [CNT_W:0] WIN_LEN = (CNT_W+1)'(SAMPLES_PER_AVERAGE);
    localparam int SCALE_W = SUM_W + GAIN_W;

    // Configuration registers.
    logic [TEMP_W-1:0]  r_target;
    logic [LIMIT_W-1:0] r_limit;
    logic [GAIN_W-1:0]  r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_limit  <= LIMIT_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TARGET: r_target <= i_cfg_data[TEMP_W-1:0];
                REG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipe steps together whenever the result slot can take a beat.
    logic adv, accept;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign accept  = i_valid && adv;

    // Window accumulator, updated at sample acceptance.
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic             win_end;

    always_comb begin
        n_sum   = r_sum + {{(SUM_W-SAMPLE_W){1'b0}}, i_sample};
        n_count = r_count + 1'b1;
        win_end = ({1'b0, n_count} >= WIN_LEN) || (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_sum   <= win_end ? '0 : n_sum;
            r_count <= win_end ? '0 : n_count;
        end
    end

    // Stage 1: window sum after the accepted sample. Stage 2: average. Stage 3: scaled reading.
    logic               r_s1_valid, r_s1_end;
    logic [SUM_W-1:0]   r_s1_sum;
    logic               r_s2_valid, r_s2_end;
    logic [SUM_W-1:0]   r_s2_avg;
    logic               r_s3_valid, r_s3_end;
    logic [TEMP_W-1:0]  r_s3_reading;
    logic               r_updated;

    logic [PROD_W-1:0]  avg_prod;
    logic [SCALE_W-1:0] scale_prod;

    assign avg_prod   = PROD_W'(r_s1_sum) * PROD_W'(RECIP);
    assign scale_prod = SCALE_W'(r_s2_avg) * SCALE_W'(r_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            o_valid    <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_end     <= win_end;
            r_s1_sum     <= n_sum;
            r_s2_end     <= r_s1_end;
            r_s2_avg     <= avg_prod[SHIFT +: SUM_W];
            r_s3_end     <= r_s2_end;
            r_s3_reading <= scale_prod[GAIN_W +: TEMP_W];
            r_updated    <= r_s3_end;
        end
    end

    // Control state lives in thc_ctrl and doubles as the result payload; it only
    // changes when a beat ending a window moves into the result slot.
    t_status status;

    thc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv && r_s3_valid && r_s3_end),
        .i_reading     (r_s3_reading),
        .i_target      (r_target),
        .i_spike_limit (r_limit),
        .o_status      (status)
    );

    assign o_updated        = r_updated;
    assign o_temperature    = status.temp;
    assign o_reading_held   = status.held;
    assign o_heater_on      = status.heater_on;
    assign o_heater_compare = status.heater_code;
    assign o_fan_compare    = status.fan_code;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for thermostat_heater_fan_controller: a directed table of sample
// windows and register writes, then random temperature windows scored by an in-bench model.
// Depends on thc_pkg and the controller RTL only.
`timescale 1ns / 100ps

module tb_top;
    import thc_pkg::*;

    // Window length used for both the instance and the in-bench model.
    localparam int WINDOW = SAMPLES_PER_AVERAGE_DEF;

    // Band offsets around the setpoint, in 1/16 degree units.
    localparam int DEADBAND     = 32;
    localparam int OUTER_BAND   = 64;
    localparam int REARM_MARGIN = 24;

    localparam int RANDOM_WINDOWS  = 75;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int REPORT_LIMIT    = 10;

    // The register map has three entries; the fourth index must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // One result beat as seen on the output ports.
    typedef struct packed {
        logic    updated;
        t_status st;
    } t_reading;

    typedef enum logic {ROW_WRITE, ROW_WINDOW} t_row_kind;

    // One line of the directed table: either a register write, or a run of identical samples.
    // When typed is set, every beat of the run must equal want.
    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic [SAMPLE_W-1:0]  value;
        logic [4:0]           count;
        logic                 typed;
        t_reading             want;
    } t_plan_row;

    // Straight after reset nothing has been averaged, so every field shows its reset value.
    localparam t_reading QUIET_START = {1'b0, 12'd0, 1'b0, 1'b0, HEAT_FULL, FAN_FULL};
    // A full-scale first window jumps far from zero and is held; zero degrees turns the heater
    // on at full power and the fan off.
    localparam t_reading FIRST_SPIKE = {1'b1, 12'd0, 1'b1, 1'b1, HEAT_FULL, FAN_OFF};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [SAMPLE_W-1:0]  i_sample;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_updated;
    logic [TEMP_W-1:0]    o_temperature;
    logic                 o_reading_held;
    logic                 o_heater_on;
    logic [CODE_W-1:0]    o_heater_compare;
    logic [CODE_W-1:0]    o_fan_compare;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    thermostat_heater_fan_controller #(
        .SAMPLES_PER_AVERAGE(WINDOW)
    ) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Thermostat model: a private copy of the registers and the state.
    // ------------------------------------------------------------------
    logic [TEMP_W-1:0]  cfg_target;
    logic [LIMIT_W-1:0] cfg_spike;
    logic [GAIN_W-1:0]  cfg_gain;

    logic [CNT_W-1:0]   win_count;
    logic [SUM_W-1:0]   win_sum;
    logic [TEMP_W-1:0]  temp_now;
    logic [TEMP_W-1:0]  temp_kept;
    logic               hold_flag;
    logic               heat_latch;
    logic               fan_armed;
    logic [CODE_W-1:0]  heat_code;
    logic [CODE_W-1:0]  fan_code;

    // Results still owed by the block, oldest first.
    t_reading pending_readings[$];
    int       fail_count = 0;

    // Temperature that the random windows drift around.
    int       walk_temp;

    // Sender and receiver each flip between a calm mode (no idle cycles) and a gappy mode.
    logic     send_calm = 1'b0;
    logic     take_calm = 1'b0;

    function automatic void thermostat_reset();
        cfg_target = TARGET_RST;
        cfg_spike  = LIMIT_RST;
        cfg_gain   = GAIN_RST;
        win_count  = '0;
        win_sum    = '0;
        temp_now   = '0;
        temp_kept  = '0;
        hold_flag  = 1'b0;
        heat_latch = 1'b0;
        fan_armed  = 1'b1;
        heat_code  = HEAT_FULL;
        fan_code   = FAN_FULL;
        walk_temp  = int'(TARGET_RST);
    endfunction

    // Takes one sample beat and returns the result beat it must cause.
    function automatic t_reading advance_thermostat(input logic [SAMPLE_W-1:0] sample);
        t_reading r;
        int       avg;
        int       reading;
        int       diff;
        int       t;
        int       tg;
        logic     was_latched;
        r = '0;
        // Sum and count wrap at their register widths, as the hardware does.
        win_sum   = win_sum + SUM_W'(sample);
        win_count = win_count + 1'b1;
        if (int'(win_count) >= WINDOW || win_count == '0) begin
            avg     = int'(win_sum) / WINDOW;
            reading = ((avg * int'(cfg_gain)) >> 8) & 'hFFF;
            win_sum   = '0;
            win_count = '0;

            // A large jump is replaced once by the last good value; the next one always passes.
            diff = reading - int'(temp_kept);
            if (diff < 0) diff = -diff;
            if (!hold_flag && diff > int'(cfg_spike)) begin
                temp_now  = temp_kept;
                hold_flag = 1'b1;
            end else begin
                temp_now  = TEMP_W'(reading);
                temp_kept = TEMP_W'(reading);
                hold_flag = 1'b0;
            end

            // All band tests are signed and use the heater latch from before this update.
            t           = int'(temp_now);
            tg          = int'(cfg_target);
            was_latched = heat_latch;

            if (t > tg - DEADBAND && t < tg + DEADBAND) begin
                if (was_latched) heat_code = HEAT_LOW;
            end else if (t > tg - OUTER_BAND && t < tg - DEADBAND) begin
                heat_code = HEAT_HIGH;
            end else if (t < tg - OUTER_BAND) begin
                heat_code = HEAT_FULL;
            end else begin
                heat_code = HEAT_OFF;
            end

            if (t > tg && t < tg + DEADBAND) begin
                if (!was_latched && fan_armed) begin
                    fan_code  = FAN_LOW;
                    fan_armed = 1'b0;
                end
            end else if (t > tg + DEADBAND && t < tg + OUTER_BAND) begin
                fan_code = FAN_HIGH;
            end else if (t >= tg + OUTER_BAND) begin
                fan_code = FAN_FULL;
            end else begin
                fan_code = FAN_OFF;
            end
            if (t < tg - REARM_MARGIN) fan_armed = 1'b1;

            // Hysteresis: on below setpoint minus two degrees, off above setpoint plus two.
            if (!was_latched && t < tg - DEADBAND) begin
                heat_latch = 1'b1;
            end else if (was_latched && t > tg + DEADBAND) begin
                heat_latch = 1'b0;
            end
            r.updated = 1'b1;
        end
        r.st.temp        = temp_now;
        r.st.held        = hold_flag;
        r.st.heater_on   = heat_latch;
        r.st.heater_code = heat_code;
        r.st.fan_code    = fan_code;
        return r;
    endfunction

    function automatic string show(input t_reading r);
        return $sformatf("upd=%0d temp=%0d held=%0d heat_on=%0d heat_cmp=%0d fan_cmp=%0d",
                         r.updated, r.st.temp, r.st.held, r.st.heater_on,
                         r.st.heater_code, r.st.fan_code);
    endfunction

    function automatic int pick_gap(input logic calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat is scored against the oldest expectation.
    // Outputs are read at the clock edge, before the block's own updates for that edge land.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_updated, o_temperature, o_reading_held, o_heater_on,
                   o_heater_compare, o_fan_compare};
            if (pending_readings.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("%0t: result beat with nothing expected: %s", $realtime, show(got));
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (got.updated !== want.updated || got.st.temp !== want.st.temp ||
                    got.st.held !== want.st.held || got.st.heater_on !== want.st.heater_on ||
                    got.st.heater_code !== want.st.heater_code ||
                    got.st.fan_code !== want.st.fan_code) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("%0t: mismatch", $realtime);
                        $display("    expected %s", show(want));
                        $display("    actual   %s", show(got));
                    end
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side.
    // ------------------------------------------------------------------

    // Offers one sample beat after a random gap and records its expected result on acceptance.
    // Valid is only dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(advance_thermostat(value));
    endtask

    // Stops offering samples until every owed result beat has been taken.
    task automatic wait_for_results();
        if (i_valid) i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // Register writes only happen with the pipeline empty. Every sample causes a result, so an
    // empty expectation queue means the block is idle. Valid stays high across consecutive
    // writes and is dropped by the next sample beat.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TARGET: cfg_target = data[TEMP_W-1:0];
            REG_LIMIT:  cfg_spike  = data[LIMIT_W-1:0];
            REG_GAIN:   cfg_gain   = data[GAIN_W-1:0];
            default:    ;
        endcase
    endtask

    // Random register settings; the bits above each register's width are random too and must
    // be dropped by the block.
    task automatic reconfigure();
        logic [CFG_DAT_W-1:0] target;
        logic [CFG_DAT_W-1:0] spike;
        logic [CFG_DAT_W-1:0] gain;
        case ($urandom_range(0, 5))
            0:       target = '0;
            1:       target = '1;
            2:       target = CFG_DAT_W'($urandom);
            default: target = CFG_DAT_W'($urandom_range(200, 900));
        endcase
        spike = CFG_DAT_W'($urandom);
        if ($urandom_range(0, 2) != 0) spike[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 60));
        gain = CFG_DAT_W'($urandom);
        case ($urandom_range(0, 5))
            0:       gain[GAIN_W-1:0] = 8'd1;
            1:       gain[GAIN_W-1:0] = 8'd255;
            default: if (gain[GAIN_W-1:0] == '0) gain[0] = 1'b1;
        endcase
        write_reg(REG_TARGET, target);
        write_reg(REG_LIMIT, spike);
        write_reg(REG_GAIN, gain);
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DAT_W'($urandom));
        walk_temp = int'(cfg_target);
    endtask

    // A run of random samples of random length, which also knocks the window phase around.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 2 * WINDOW);
        repeat (n) send_sample(SAMPLE_W'($urandom));
    endtask

    // One aligned window whose average scales to a chosen temperature exactly. The target is
    // picked on or next to a band edge, near the setpoint, or as a drift from the last one.
    // Samples come in pairs spread evenly around the average so the sum is unchanged.
    task automatic send_shaped_window();
        int top;
        int t_want;
        int avg;
        int spread;
        int d;
        int band_offs[6] = '{-OUTER_BAND, -DEADBAND, -REARM_MARGIN, 0, DEADBAND, OUTER_BAND};
        // Finish a window left open by noise so the next beat starts a fresh one.
        while (win_count != '0) send_sample(SAMPLE_W'($urandom));
        top = (4095 * int'(cfg_gain)) >> 8;
        case ($urandom_range(0, 3))
            0:       t_want = int'(cfg_target) + band_offs[$urandom_range(0, 5)]
                              + int'($urandom_range(0, 2)) - 1;
            1:       t_want = int'(cfg_target) + int'($urandom_range(0, 200)) - 100;
            default: t_want = walk_temp + int'($urandom_range(0, 60)) - 30;
        endcase
        if (t_want < 0) t_want = 0;
        if (t_want > top) t_want = top;
        walk_temp = t_want;
        // Smallest average that reaches t_want; the floor of the scaling then lands on it.
        avg    = (t_want * 256 + int'(cfg_gain) - 1) / int'(cfg_gain);
        spread = (avg < 4095 - avg) ? avg : 4095 - avg;
        if (spread > 300) spread = 300;
        for (int k = 0; k < WINDOW / 2; k++) begin
            d = int'($urandom_range(0, spread));
            send_sample(SAMPLE_W'(avg + d));
            send_sample(SAMPLE_W'(avg - d));
        end
        if (WINDOW % 2 != 0) send_sample(SAMPLE_W'(avg));
    endtask

    function automatic t_plan_row win_row(input logic [SAMPLE_W-1:0] value, input int count,
                                          input logic typed, input t_reading want);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_WINDOW;
        row.value = value;
        row.count = 5'(count);
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic t_plan_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] data);
        t_plan_row row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random windows, then drain and verdict.
    // ------------------------------------------------------------------
    initial begin : drive_samples
        t_plan_row plan[$];
        t_plan_row row;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        thermostat_reset();

        plan = '{
            // First window at full scale: nine quiet beats, then a held spike.
            win_row(12'hFFF, 9, 1'b1, QUIET_START),
            win_row(12'hFFF, 1, 1'b1, FIRST_SPIKE),
            // The reading after a hold always passes; then the same swing down to zero.
            win_row(12'hFFF, 10, 1'b0, '0),
            win_row(12'h000, 10, 1'b0, '0),
            win_row(12'h000, 10, 1'b0, '0),
            // The unmapped index must change nothing.
            reg_row(REG_SPARE, 12'hFFF),
            // Zero gain: any average scales to zero degrees.
            reg_row(REG_GAIN, 12'h100),
            win_row(12'd2000, 10, 1'b0, '0),
            reg_row(REG_GAIN, 12'h0FF),
            reg_row(REG_LIMIT, 12'hFFF),
            // Setpoint at the bottom of the range: bands below it must not wrap.
            reg_row(REG_TARGET, 12'h000),
            win_row(12'd1, 10, 1'b0, '0),
            win_row(12'd20, 10, 1'b0, '0),
            // Setpoint at the top of the range.
            reg_row(REG_TARGET, 12'hFFF),
            win_row(12'hFFF, 10, 1'b0, '0),
            win_row(12'hFFF, 10, 1'b0, '0),
            // No spike allowance at all: every change is held once.
            reg_row(REG_LIMIT, 12'hF00),
            win_row(12'd4000, 10, 1'b0, '0),
            win_row(12'd4000, 10, 1'b0, '0),
            reg_row(REG_TARGET, 12'd400),
            reg_row(REG_LIMIT, 12'd24),
            reg_row(REG_GAIN, 12'hAB2)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.data);
            end else begin
                repeat (row.count) begin
                    send_sample(row.value);
                    if (row.typed) pending_readings[pending_readings.size() - 1] = row.want;
                end
            end
        end

        // Random part: mostly aligned windows aimed at the bands, with some noise mixed in.
        // Each reconfiguration first waits for the pipeline to empty.
        for (int w = 0; w < RANDOM_WINDOWS; w++) begin
            if (w % 15 == 0) reconfigure();
            if ($urandom_range(0, 4) == 0 || cfg_gain == '0) begin
                send_noise();
            end else begin
                send_shaped_window();
            end
        end

        i_valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_readings.size() != 0; k++)
            @(posedge i_clk);
        // Wait beyond the pipeline depth, to catch any stray result beat.
        repeat (8) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            $display("%0d expected results never arrived", pending_readings.size());
            fail_count += pending_readings.size();
        end
        if (fail_count == 0) begin
            $display("thermostat_heater_fan_controller regression: pass");
        end else begin
            $display("thermostat_heater_fan_controller regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, plus two long hold-offs. During a hold-off the sample
    // side keeps offering beats, so the pipeline fills and o_ready has to drop.
    // ------------------------------------------------------------------
    initial begin : take_results
        int taken;
        int gap;
        taken = 0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            gap = (taken == 250 || taken == 700) ? HOLD_OFF_CYCLES : pick_gap(take_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    // Watchdog, several times the slowest legal run.
    initial begin : watchdog
        #3000000;
        $display("thermostat_heater_fan_controller regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/thc_pkg.sv
rtl/core/thc_ctrl.sv
rtl/core/thermostat_heater_fan_controller.sv
tb/tb_top.sv
